// ----- hw/rtl/tpsdds_pkg.sv -----
// Shared types and constants for the test-pulse sweep DDS programmer.
// No dependencies; every other file in hw/rtl imports this package.
package tpsdds_pkg;

    // APB register port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Register map, word index (byte address / 4)
    localparam logic [1:0] REG_FREQ_COUNT  = 2'd0;
    localparam logic [1:0] REG_ATTEN_STEP  = 2'd1;
    localparam logic [1:0] REG_ATTEN_LIMIT = 2'd2;

    // Register widths and reset values
    localparam int FC_W   = 4;
    localparam int STEP_W = 6;
    localparam int LIM_W  = 7;
    localparam logic [FC_W-1:0]   FREQ_COUNT_RST  = 4'd1;
    localparam logic [STEP_W-1:0] ATTEN_STEP_RST  = 6'd1;
    localparam logic [LIM_W-1:0]  ATTEN_LIMIT_RST = 7'd127;

    // Item field widths
    localparam int SEL_W  = 2;
    localparam int IDX_W  = 3;
    localparam int VAL_W  = 35;
    localparam int FREQ_W = 34;
    localparam int FNUM_W = 4;
    localparam int ATT_W  = 8;
    localparam int BAND_W = 7;
    localparam int TUNE_W = 30;

    // Operation and table codes
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;
    localparam logic [SEL_W-1:0] TBL_FORE_BASE = 2'd0;
    localparam logic [SEL_W-1:0] TBL_FORE_OFS  = 2'd1;
    localparam logic [SEL_W-1:0] TBL_AFT_BASE  = 2'd2;
    localparam logic [SEL_W-1:0] TBL_AFT_OFS   = 2'd3;

    // Channel codes
    localparam logic CH_FORE = 1'b0;
    localparam logic CH_AFT  = 1'b1;

    // Frequency limits and DDS constants (Hz)
    localparam int SUM_W  = 36;
    localparam int DIFF_W = 32;
    localparam int DEN_W  = 27;
    localparam int DVD_W  = 57;
    localparam logic [FREQ_W-1:0] F_LOW  = 34'd8000000000;
    localparam logic [FREQ_W-1:0] F_HIGH = 34'd10799999999;
    localparam logic [FREQ_W-1:0] F_TOP  = 34'd10860000000;
    localparam logic [19:0]       DDS_DIV  = 20'd703125;
    localparam logic [8:0]        BAND_TOP = 9'd361;
    localparam logic [24:0]       BAND_DIV = 25'd30000000;

    // Band quotient: f / 30e6 = ((f >> 7) * BAND_RECIP) >> 45, exact for
    // any 27-bit f >> 7 (BAND_RECIP = ceil(2^45 / 234375))
    localparam logic [27:0] BAND_RECIP = 28'd150119988;

    // Tuning-word restoring divider
    localparam int DIV_REM_W = 28;
    localparam int DIV_LOW_W = 30;
    localparam int DIV_CNT_W = 5;
    localparam logic [DIV_CNT_W-1:0] TUNE_STEPS = 5'd30;

    typedef struct packed {
        logic [FC_W-1:0]   freq_count;
        logic [STEP_W-1:0] atten_step;
        logic [LIM_W-1:0]  atten_limit;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic write_entry;
        logic read_tables;
        logic sum;
        logic band_take;
        logic den;
        logic tune_start;
        logic tune_take;
        logic emit;
        logic update;
        logic chan;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_valid;
        logic in_advance;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

// ----- hw/rtl/tpsdds_intf.sv -----
// Valid/ready channel interfaces for request and result beats.
// Depends on tpsdds_pkg for field widths.
interface tpsdds_in_if;
    import tpsdds_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    operation;
    logic [SEL_W-1:0]        table_select;
    logic [IDX_W-1:0]        entry_index;
    logic signed [VAL_W-1:0] entry_value;

    modport source (output valid, operation, table_select, entry_index, entry_value,
                    input ready);
    modport sink   (input valid, operation, table_select, entry_index, entry_value,
                    output ready);
endinterface

interface tpsdds_out_if;
    import tpsdds_pkg::*;

    logic              valid;
    logic              ready;
    logic              channel;
    logic [FNUM_W-1:0] freq_number;
    logic [FREQ_W-1:0] frequency_hz;
    logic [ATT_W-1:0]  attenuation;
    logic [BAND_W-1:0] dds_band;
    logic [TUNE_W-1:0] dds_tuning;
    logic              last;

    modport source (output valid, channel, freq_number, frequency_hz, attenuation,
                    dds_band, dds_tuning, last, input ready);
    modport sink   (input valid, channel, freq_number, frequency_hz, attenuation,
                    dds_band, dds_tuning, last, output ready);
endinterface

// ----- hw/rtl/tpsdds_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on tpsdds_pkg; used for the tuning-word division.
module tpsdds_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [tpsdds_pkg::DIV_REM_W-1:0]   i_rem,
    input  logic [tpsdds_pkg::DIV_LOW_W-1:0]   i_low,
    input  logic [tpsdds_pkg::DIV_REM_W-1:0]   i_divisor,
    input  logic [tpsdds_pkg::DIV_CNT_W-1:0]   i_steps,
    output logic                               o_done,
    output logic [tpsdds_pkg::DIV_LOW_W-1:0]   o_quot
);
    import tpsdds_pkg::*;

    logic [DIV_REM_W-1:0] r_rem;
    logic [DIV_LOW_W-1:0] r_low;
    logic [DIV_REM_W-1:0] r_div;
    logic [DIV_CNT_W-1:0] r_count;
    logic                 r_done;

    logic [DIV_REM_W:0]   w_trial;
    logic [DIV_REM_W:0]   w_sub;
    logic                 w_fits;

    // Trial subtract of the shifted partial remainder
    assign w_trial = {r_rem, r_low[DIV_LOW_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_div});
    assign w_sub   = w_trial - {1'b0, r_div};

    // Step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_count <= i_steps;
            end else if (r_count != '0) begin
                r_count <= r_count - 1'b1;
                if (r_count == DIV_CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and dividend/quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem;
            r_low <= i_low;
            r_div <= i_divisor;
        end else if (r_count != '0) begin
            r_rem <= w_fits ? w_sub[DIV_REM_W-1:0] : w_trial[DIV_REM_W-1:0];
            r_low <= {r_low[DIV_LOW_W-2:0], w_fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_low;

endmodule

// ----- hw/rtl/tpsdds_dpath.sv -----
// Datapath: entry tables, sweep counters, frequency/band/tuning arithmetic
// and the result register. Depends on tpsdds_pkg, tpsdds_intf, tpsdds_div.
module tpsdds_dpath #(
    parameter int MAX_FREQS   = 8,
    parameter int NUM_OFFSETS = 7
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tpsdds_pkg::t_cmd                    i_cmd,
    input  tpsdds_pkg::t_cfg                    i_cfg,
    input  logic                                i_valid,
    input  logic                                i_operation,
    input  logic [tpsdds_pkg::SEL_W-1:0]        i_table_select,
    input  logic [tpsdds_pkg::IDX_W-1:0]        i_entry_index,
    input  logic signed [tpsdds_pkg::VAL_W-1:0] i_entry_value,
    output tpsdds_pkg::t_sts                    o_sts,
    tpsdds_out_if.source                        o_out
);
    import tpsdds_pkg::*;

    localparam int FI_W  = (MAX_FREQS > 1) ? $clog2(MAX_FREQS) : 1;
    localparam int OI_W  = (NUM_OFFSETS > 1) ? $clog2(NUM_OFFSETS) : 1;
    localparam int CNT_W = (FI_W + 1 > 5) ? FI_W + 1 : 5;

    // Tables
    logic [FREQ_W-1:0]       r_fore_base [MAX_FREQS];
    logic [FREQ_W-1:0]       r_aft_base  [MAX_FREQS];
    logic signed [VAL_W-1:0] r_fore_ofs  [NUM_OFFSETS];
    logic signed [VAL_W-1:0] r_aft_ofs   [NUM_OFFSETS];

    // Sweep state
    logic [FI_W-1:0]   r_freq_index;
    logic [OI_W-1:0]   r_offset_index;
    logic [ATT_W-1:0]  r_atten_now;
    logic [STEP_W-1:0] r_atten_start;

    // Working registers
    logic [FREQ_W-1:0]       r_fb;
    logic [FREQ_W-1:0]       r_ab;
    logic signed [VAL_W-1:0] r_fo;
    logic signed [VAL_W-1:0] r_ao;
    logic [FREQ_W-1:0]       r_freq;
    logic [DIFF_W-1:0]       r_diff;
    logic [BAND_W-1:0]       r_band;
    logic [DEN_W-1:0]        r_den;
    logic [TUNE_W-1:0]       r_tune;

    // Result register
    logic              r_out_valid;
    logic              r_out_channel;
    logic [FNUM_W-1:0] r_out_fnum;
    logic [FREQ_W-1:0] r_out_freq;
    logic [ATT_W-1:0]  r_out_att;
    logic [BAND_W-1:0] r_out_band;
    logic [TUNE_W-1:0] r_out_tune;
    logic              r_out_last;

    logic                     w_base_ok;
    logic                     w_ofs_ok;
    logic [FI_W-1:0]          w_base_addr;
    logic [OI_W-1:0]          w_ofs_addr;
    logic [FREQ_W-1:0]        w_base_sel;
    logic signed [VAL_W-1:0]  w_ofs_sel;
    logic signed [SUM_W-1:0]  w_sum;
    logic [FREQ_W-1:0]        w_sat;
    logic [FREQ_W-1:0]        w_diff_full;
    logic [54:0]              w_band_prod;
    logic [8:0]               w_band_full;
    logic [7:0]               w_band_p1;
    logic [27:0]              w_den_prod;
    logic [DVD_W-1:0]         w_dividend;
    logic                     w_div_start;
    logic [DIV_REM_W-1:0]     w_div_rem;
    logic [DIV_LOW_W-1:0]     w_div_low;
    logic [DIV_REM_W-1:0]     w_div_divisor;
    logic [DIV_CNT_W-1:0]     w_div_steps;
    logic                     w_div_done;
    logic [DIV_LOW_W-1:0]     w_quot;
    logic [CNT_W-1:0]         w_count;
    logic [CNT_W-1:0]         w_fi_inc;
    logic                     w_wrap;
    logic [8:0]               w_att_sum;
    logic                     w_pass;
    logic [STEP_W:0]          w_start_inc;
    logic [STEP_W-1:0]        w_start_next;
    logic [OI_W:0]            w_oi_inc;
    logic [OI_W-1:0]          w_oi_next;

    // Load decode; out-of-range entries are dropped
    assign w_base_ok   = (int'(i_entry_index) < MAX_FREQS);
    assign w_ofs_ok    = (int'(i_entry_index) < NUM_OFFSETS);
    assign w_base_addr = FI_W'(i_entry_index);
    assign w_ofs_addr  = OI_W'(i_entry_index);

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_entry) begin
            unique case (i_table_select)
                TBL_FORE_BASE: if (w_base_ok) r_fore_base[w_base_addr] <= i_entry_value[FREQ_W-1:0];
                TBL_AFT_BASE:  if (w_base_ok) r_aft_base[w_base_addr]  <= i_entry_value[FREQ_W-1:0];
                TBL_FORE_OFS:  if (w_ofs_ok)  r_fore_ofs[w_ofs_addr]   <= i_entry_value;
                TBL_AFT_OFS:   if (w_ofs_ok)  r_aft_ofs[w_ofs_addr]    <= i_entry_value;
                default: ;
            endcase
        end
    end

    // Base + offset, clamped into the transmit band
    assign w_base_sel = (i_cmd.chan == CH_AFT) ? r_ab : r_fb;
    assign w_ofs_sel  = (i_cmd.chan == CH_AFT) ? r_ao : r_fo;
    assign w_sum      = $signed({2'b00, w_base_sel}) + SUM_W'(w_ofs_sel);

    always_comb begin
        if (w_sum < $signed({2'b00, F_LOW})) begin
            w_sat = F_LOW;
        end else if (w_sum > $signed({2'b00, F_HIGH})) begin
            w_sat = F_HIGH;
        end else begin
            w_sat = w_sum[FREQ_W-1:0];
        end
    end

    // Band by reciprocal multiply, denominator and rounded-division operand
    assign w_diff_full = F_TOP - r_freq;
    assign w_band_prod = 55'(r_freq[FREQ_W-1:7]) * 55'(BAND_RECIP);
    assign w_band_full = BAND_TOP - w_band_prod[53:45];
    assign w_band_p1   = {1'b0, r_band} + 8'd1;
    assign w_den_prod  = 28'(DDS_DIV) * 28'(w_band_p1);
    assign w_dividend  = {r_diff, 25'b0} + DVD_W'(r_den);

    // Divider operands for the tuning word
    assign w_div_start   = i_cmd.tune_start;
    assign w_div_rem     = DIV_REM_W'(w_dividend[DVD_W-1:DIV_LOW_W]);
    assign w_div_low     = w_dividend[DIV_LOW_W-1:0];
    assign w_div_divisor = {r_den, 1'b0};
    assign w_div_steps   = TUNE_STEPS;

    tpsdds_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_rem     (w_div_rem),
        .i_low     (w_div_low),
        .i_divisor (w_div_divisor),
        .i_steps   (w_div_steps),
        .o_done    (w_div_done),
        .o_quot    (w_quot)
    );

    // Arithmetic pipeline registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.read_tables) begin
            r_fb <= r_fore_base[r_freq_index];
            r_ab <= r_aft_base[r_freq_index];
            r_fo <= r_fore_ofs[r_offset_index];
            r_ao <= r_aft_ofs[r_offset_index];
        end
        if (i_cmd.sum) begin
            r_freq <= w_sat;
        end
        if (i_cmd.band_take) begin
            r_diff <= w_diff_full[DIFF_W-1:0];
            r_band <= w_band_full[BAND_W-1:0];
        end
        if (i_cmd.den) begin
            r_den <= w_den_prod[DEN_W-1:0];
        end
        if (i_cmd.tune_take) begin
            r_tune <= w_quot[TUNE_W-1:0];
        end
    end

    // Sweep counter next values
    assign w_count      = (int'(i_cfg.freq_count) > MAX_FREQS) ? CNT_W'(MAX_FREQS)
                                                               : CNT_W'(i_cfg.freq_count);
    assign w_fi_inc     = CNT_W'(r_freq_index) + 1'b1;
    assign w_wrap       = (w_fi_inc >= w_count);
    assign w_att_sum    = 9'(r_atten_now) + 9'(i_cfg.atten_step);
    assign w_pass       = (w_att_sum > 9'(i_cfg.atten_limit));
    assign w_start_inc  = {1'b0, r_atten_start} + 1'b1;
    assign w_start_next = (w_start_inc >= {1'b0, i_cfg.atten_step}) ? '0
                                                                    : w_start_inc[STEP_W-1:0];
    assign w_oi_inc     = {1'b0, r_offset_index} + 1'b1;
    assign w_oi_next    = (w_oi_inc >= (OI_W+1)'(NUM_OFFSETS)) ? '0 : w_oi_inc[OI_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq_index   <= '0;
            r_offset_index <= '0;
            r_atten_now    <= '0;
            r_atten_start  <= '0;
        end else if (i_cmd.update) begin
            if (w_wrap) begin
                r_freq_index <= '0;
                if (w_pass) begin
                    r_atten_start  <= w_start_next;
                    r_atten_now    <= ATT_W'(w_start_next);
                    r_offset_index <= w_oi_next;
                end else begin
                    r_atten_now <= w_att_sum[ATT_W-1:0];
                end
            end else begin
                r_freq_index <= w_fi_inc[FI_W-1:0];
            end
        end
    end

    // Result register: loads while the previous beat drains
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_channel <= i_cmd.chan;
            r_out_fnum    <= w_fi_inc[FNUM_W-1:0];
            r_out_freq    <= r_freq;
            r_out_att     <= r_atten_now;
            r_out_band    <= r_band;
            r_out_tune    <= r_tune;
            r_out_last    <= (i_cmd.chan == CH_AFT) && w_wrap && w_pass;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.channel      = r_out_channel;
    assign o_out.freq_number  = r_out_fnum;
    assign o_out.frequency_hz = r_out_freq;
    assign o_out.attenuation  = r_out_att;
    assign o_out.dds_band     = r_out_band;
    assign o_out.dds_tuning   = r_out_tune;
    assign o_out.last         = r_out_last;

    // Status to controller
    assign o_sts.in_valid   = i_valid;
    assign o_sts.in_advance = (i_operation == OP_ADVANCE);
    assign o_sts.div_done   = w_div_done;
    assign o_sts.out_free   = !r_out_valid || o_out.ready;

    // Checks
    a_freq_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_freq_index) < MAX_FREQS)
        else $error("frequency index out of range");

    a_offset_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_offset_index) < NUM_OFFSETS)
        else $error("offset index out of range");

    a_atten_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_atten_now <= ATT_W'(127))
        else $error("stored attenuation above 127");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_out_valid)
        else $error("result beat lost after emit");

    a_last_on_aft: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_out_channel == CH_AFT))
        else $error("last flag on a fore beat");

endmodule

// ----- hw/rtl/tpsdds_ctrl.sv -----
// Controller: sequences loads and the fore/aft result computation.
// Depends on tpsdds_pkg; drives the datapath through t_cmd.
module tpsdds_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tpsdds_pkg::t_sts i_sts,
    output tpsdds_pkg::t_cmd o_cmd,
    output logic             o_in_ready
);
    import tpsdds_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_SUM,
        S_BAND,
        S_DEN,
        S_TUNE,
        S_TUNE_WAIT,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_chan;
    logic   n_chan;
    t_cmd   w_cmd;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_chan      = r_chan;
        w_cmd       = '0;
        w_cmd.chan  = r_chan;
        unique case (r_state)
            S_IDLE: begin
                if (i_sts.in_valid) begin
                    if (i_sts.in_advance) begin
                        n_chan  = CH_FORE;
                        n_state = S_READ;
                    end else begin
                        w_cmd.write_entry = 1'b1;
                    end
                end
            end
            S_READ: begin
                w_cmd.read_tables = 1'b1;
                n_state           = S_SUM;
            end
            S_SUM: begin
                w_cmd.sum = 1'b1;
                n_state   = S_BAND;
            end
            S_BAND: begin
                w_cmd.band_take = 1'b1;
                n_state         = S_DEN;
            end
            S_DEN: begin
                w_cmd.den = 1'b1;
                n_state   = S_TUNE;
            end
            S_TUNE: begin
                w_cmd.tune_start = 1'b1;
                n_state          = S_TUNE_WAIT;
            end
            S_TUNE_WAIT: begin
                if (i_sts.div_done) begin
                    w_cmd.tune_take = 1'b1;
                    n_state         = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    w_cmd.emit = 1'b1;
                    if (r_chan == CH_FORE) begin
                        n_chan  = CH_AFT;
                        n_state = S_SUM;
                    end else begin
                        w_cmd.update = 1'b1;
                        n_state      = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_chan  <= CH_FORE;
        end else begin
            r_state <= n_state;
            r_chan  <= n_chan;
        end
    end

    assign o_cmd      = w_cmd;
    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ----- hw/rtl/test_pulse_sweep_dds_programmer_top.sv -----
// Test-pulse sweep DDS programmer: top level with APB registers.
// Depends on tpsdds_pkg, tpsdds_intf, tpsdds_ctrl, tpsdds_dpath.
//
// A load beat writes one fore/aft base or offset table entry, and the input
// stays ready for the next beat. An advance beat returns two result beats,
// fore then aft, and the input is ready again once the aft beat is emitted:
// each result takes a reciprocal multiply for the band, a 30-step tuning-word
// division on a bit-serial divider, plus add, clamp and multiply steps; a
// stalled result port adds its stall time. The
// aft beat can wait in the output register while the next input beat is
// taken. Tables are not initialized: every entry that an advance uses must
// have been loaded first. Registers at byte address 0x0 freq_count, 0x4
// atten_step, 0x8 atten_limit; write them only while the block is idle.
module test_pulse_sweep_dds_programmer_top #(
    parameter int MAX_FREQS   = 8,
    parameter int NUM_OFFSETS = 7
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tpsdds_pkg::APB_AW-1:0]  paddr,
    input  logic [tpsdds_pkg::APB_DW-1:0]  pwdata,
    output logic [tpsdds_pkg::APB_DW-1:0]  prdata,
    output logic                           pready,
    tpsdds_in_if.sink                      i_in,
    tpsdds_out_if.source                   o_out
);
    import tpsdds_pkg::*;

    logic [FC_W-1:0]   r_freq_count;
    logic [STEP_W-1:0] r_atten_step;
    logic [LIM_W-1:0]  r_atten_limit;
    logic              w_wr;
    logic [1:0]        w_reg;
    t_cfg              w_cfg;
    t_cmd              w_cmd;
    t_sts              w_sts;
    logic              w_in_ready;

    // APB register file
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_reg  = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq_count  <= FREQ_COUNT_RST;
            r_atten_step  <= ATTEN_STEP_RST;
            r_atten_limit <= ATTEN_LIMIT_RST;
        end else if (w_wr) begin
            unique case (w_reg)
                REG_FREQ_COUNT:  r_freq_count  <= pwdata[FC_W-1:0];
                REG_ATTEN_STEP:  r_atten_step  <= pwdata[STEP_W-1:0];
                REG_ATTEN_LIMIT: r_atten_limit <= pwdata[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_FREQ_COUNT:  prdata = APB_DW'(r_freq_count);
            REG_ATTEN_STEP:  prdata = APB_DW'(r_atten_step);
            REG_ATTEN_LIMIT: prdata = APB_DW'(r_atten_limit);
            default:         prdata = '0;
        endcase
    end

    assign w_cfg.freq_count  = r_freq_count;
    assign w_cfg.atten_step  = r_atten_step;
    assign w_cfg.atten_limit = r_atten_limit;

    assign i_in.ready = w_in_ready;

    tpsdds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_ready (w_in_ready)
    );

    tpsdds_dpath #(
        .MAX_FREQS   (MAX_FREQS),
        .NUM_OFFSETS (NUM_OFFSETS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_cfg          (w_cfg),
        .i_valid        (i_in.valid),
        .i_operation    (i_in.operation),
        .i_table_select (i_in.table_select),
        .i_entry_index  (i_in.entry_index),
        .i_entry_value  (i_in.entry_value),
        .o_sts          (w_sts),
        .o_out          (o_out)
    );

endmodule

// ----- test/testbench.sv -----
// Self-checking bench for the test-pulse sweep DDS programmer.
// Needs tpsdds_pkg, tpsdds_intf and test_pulse_sweep_dds_programmer_top.
`timescale 1ns / 1ps

module testbench;
    import tpsdds_pkg::*;

    localparam int          NUM_BASE   = 8;
    localparam int          NUM_OFS    = 7;
    localparam int          SETTLE     = 120;
    localparam int          PHASE_CMDS = 125;
    localparam int unsigned MAX_CYCLES = 400000;

    typedef struct {
        logic                    operation;
        logic [SEL_W-1:0]        table_select;
        logic [IDX_W-1:0]        entry_index;
        logic signed [VAL_W-1:0] entry_value;
    } sweep_cmd_t;

    typedef struct {
        logic              channel;
        logic [FNUM_W-1:0] freq_number;
        logic [FREQ_W-1:0] frequency_hz;
        logic [ATT_W-1:0]  attenuation;
        logic [BAND_W-1:0] dds_band;
        logic [TUNE_W-1:0] dds_tuning;
        logic              last;
    } dds_program_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    tpsdds_in_if  cmd_ch ();
    tpsdds_out_if prog_ch ();

    test_pulse_sweep_dds_programmer_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (cmd_ch),
        .o_out   (prog_ch)
    );

    always #5 i_clk = ~i_clk;

    // Stimulus and expectation stores
    sweep_cmd_t   sweep_cmds[$];
    sweep_cmd_t   cmd_on_bus;
    dds_program_t due_programs[$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned errors;
    int unsigned cycle_count;
    int unsigned n_loads;
    int unsigned n_advances;
    int unsigned n_beats;
    int unsigned n_last;

    // Shadow registers and sweep state
    logic [FC_W-1:0]   cfg_fc;
    logic [STEP_W-1:0] cfg_step;
    logic [LIM_W-1:0]  cfg_limit;
    int unsigned       freq_idx;
    int unsigned       ofs_idx;
    int unsigned       att_now;
    int unsigned       att_start;
    logic [FREQ_W-1:0]       fore_base[NUM_BASE];
    logic [FREQ_W-1:0]       aft_base[NUM_BASE];
    logic signed [VAL_W-1:0] fore_ofs[NUM_OFS];
    logic signed [VAL_W-1:0] aft_ofs[NUM_OFS];

    // Register settings per random phase: frequency count, step, limit
    int unsigned phase_fc[6]    = '{3, 0, 15, 8, 1, 4};
    int unsigned phase_step[6]  = '{20, 63, 5, 0, 1, 63};
    int unsigned phase_limit[6] = '{100, 127, 30, 0, 0, 126};

    // Frequency clamp, band and rounded tuning word for one radar
    function automatic dds_program_t dds_program(input logic ch, input int unsigned fidx,
                                                 input logic [FREQ_W-1:0] base,
                                                 input logic signed [VAL_W-1:0] ofs,
                                                 input int unsigned att, input logic lst);
        longint          b;
        longint          o;
        longint          f;
        longint unsigned fu;
        longint unsigned band;
        longint unsigned den;
        longint unsigned num;
        longint unsigned tune;
        dds_program_t    p;
        b = base;
        o = ofs;
        f = b + o;
        if (f < longint'(F_LOW)) f = longint'(F_LOW);
        if (f > longint'(F_HIGH)) f = longint'(F_HIGH);
        fu   = f;
        band = 64'(BAND_TOP) - fu / 64'(BAND_DIV);
        den  = 64'(DDS_DIV) * (band + 64'd1);
        num  = (64'(F_TOP) - fu) << 24;
        tune = (64'd2 * num + den) / (64'd2 * den);
        p.channel      = ch;
        p.freq_number  = FNUM_W'(fidx + 1);
        p.frequency_hz = fu[FREQ_W-1:0];
        p.attenuation  = ATT_W'(att);
        p.dds_band     = band[BAND_W-1:0];
        p.dds_tuning   = tune[TUNE_W-1:0];
        p.last         = lst;
        return p;
    endfunction

    // Table loads, or two programs per advance followed by the sweep step
    task automatic sequence_sweep(input sweep_cmd_t c);
        int unsigned             cnt;
        int unsigned             nxt;
        int unsigned             sum;
        int unsigned             att;
        logic                    wrapped;
        logic [FREQ_W-1:0]       ab;
        logic signed [VAL_W-1:0] ao;
        if (c.operation == OP_LOAD) begin
            n_loads++;
            case (c.table_select)
                TBL_FORE_BASE: fore_base[c.entry_index] = c.entry_value[FREQ_W-1:0];
                TBL_AFT_BASE:  aft_base[c.entry_index]  = c.entry_value[FREQ_W-1:0];
                TBL_FORE_OFS:  if (c.entry_index < NUM_OFS) fore_ofs[c.entry_index] = c.entry_value;
                default:       if (c.entry_index < NUM_OFS) aft_ofs[c.entry_index] = c.entry_value;
            endcase
        end else begin
            n_advances++;
            att = att_now;
            ab  = aft_base[freq_idx];
            ao  = aft_ofs[ofs_idx];
            cnt = (cfg_fc > NUM_BASE) ? NUM_BASE : cfg_fc;
            due_programs.push_back(dds_program(CH_FORE, freq_idx, fore_base[freq_idx],
                                               fore_ofs[ofs_idx], att, 1'b0));
            wrapped = 1'b0;
            nxt = freq_idx + 1;
            if (nxt + 1 > cnt) begin
                nxt = 0;
                sum = att_now + cfg_step;
                if (sum > cfg_limit) begin
                    wrapped = 1'b1;
                    att_start = att_start + 1;
                    if (att_start >= cfg_step) att_start = 0;
                    att_now = att_start & 6'h3F;
                    ofs_idx = (ofs_idx + 1 >= NUM_OFS) ? 0 : ofs_idx + 1;
                end else begin
                    att_now = sum & 8'hFF;
                end
            end
            due_programs.push_back(dds_program(CH_AFT, freq_idx, ab, ao, att, wrapped));
            freq_idx = nxt;
        end
    endtask

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    task automatic check_program();
        dds_program_t want;
        if (due_programs.size() == 0) begin
            $error("result beat with nothing expected");
            errors++;
        end else begin
            want = due_programs.pop_front();
            n_beats++;
            if (want.last) n_last++;
            check_field("channel", want.channel, prog_ch.channel);
            check_field("freq_number", want.freq_number, prog_ch.freq_number);
            check_field("frequency_hz", want.frequency_hz, prog_ch.frequency_hz);
            check_field("attenuation", want.attenuation, prog_ch.attenuation);
            check_field("dds_band", want.dds_band, prog_ch.dds_band);
            check_field("dds_tuning", want.dds_tuning, prog_ch.dds_tuning);
            check_field("last", want.last, prog_ch.last);
        end
    endtask

    // Command driver: take the beat on an accept, then offer the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else begin
            if (cmd_ch.valid && cmd_ch.ready) sequence_sweep(cmd_on_bus);
            if (!cmd_ch.valid || cmd_ch.ready) begin
                if (sweep_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cmd_on_bus = sweep_cmds.pop_front();
                    cmd_ch.valid        <= 1'b1;
                    cmd_ch.operation    <= cmd_on_bus.operation;
                    cmd_ch.table_select <= cmd_on_bus.table_select;
                    cmd_ch.entry_index  <= cmd_on_bus.entry_index;
                    cmd_ch.entry_value  <= cmd_on_bus.entry_value;
                end else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            prog_ch.ready <= 1'b0;
        end else begin
            if (prog_ch.valid && prog_ch.ready) check_program();
            prog_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_load(input logic [SEL_W-1:0] sel, input logic [IDX_W-1:0] idx,
                             input logic signed [VAL_W-1:0] val);
        sweep_cmd_t c;
        c.operation    = OP_LOAD;
        c.table_select = sel;
        c.entry_index  = idx;
        c.entry_value  = val;
        sweep_cmds.push_back(c);
    endtask

    task automatic send_advance();
        sweep_cmd_t c;
        c.operation    = OP_ADVANCE;
        c.table_select = SEL_W'($urandom);
        c.entry_index  = IDX_W'($urandom);
        c.entry_value  = VAL_W'({$urandom, $urandom});
        sweep_cmds.push_back(c);
    endtask

    function automatic logic signed [VAL_W-1:0] plausible_base();
        return VAL_W'(64'd7900000000 + 64'($urandom_range(0, 32'd3000000000)));
    endfunction

    function automatic logic signed [VAL_W-1:0] plausible_offset();
        longint o;
        o = longint'($urandom_range(0, 400000000)) - 200000000;
        return VAL_W'(o);
    endfunction

    // Mostly sensible frequencies; a share of raw values covers every bit
    task automatic send_random_cmd();
        logic [SEL_W-1:0]        sel;
        logic signed [VAL_W-1:0] val;
        if ($urandom_range(99) < 55) begin
            send_advance();
        end else begin
            sel = SEL_W'($urandom);
            if ($urandom_range(99) < 30) val = VAL_W'({$urandom, $urandom});
            else if (sel == TBL_FORE_BASE || sel == TBL_AFT_BASE) val = plausible_base();
            else val = plausible_offset();
            send_load(sel, IDX_W'($urandom), val);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [APB_DW-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FREQ_COUNT: cfg_fc    = data[FC_W-1:0];
            REG_ATTEN_STEP: cfg_step  = data[STEP_W-1:0];
            default:        cfg_limit = data[LIM_W-1:0];
        endcase
    endtask

    // Wait for every beat to go in and every program to come out
    task automatic drain();
        while (sweep_cmds.size() != 0 || cmd_ch.valid || due_programs.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        cmd_ch.valid        = 1'b0;
        cmd_ch.operation    = OP_LOAD;
        cmd_ch.table_select = TBL_FORE_BASE;
        cmd_ch.entry_index  = '0;
        cmd_ch.entry_value  = '0;
        prog_ch.ready       = 1'b0;
        cycle_count = 0;
        errors      = 0;
        n_loads     = 0;
        n_advances  = 0;
        n_beats     = 0;
        n_last      = 0;
        cfg_fc      = FREQ_COUNT_RST;
        cfg_step    = ATTEN_STEP_RST;
        cfg_limit   = ATTEN_LIMIT_RST;
        freq_idx    = 0;
        ofs_idx     = 0;
        att_now     = 0;
        att_start   = 0;
        send_idle_pct = 27;
        recv_idle_pct = 75;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fill every table entry before anything can read it
        for (int i = 0; i < NUM_BASE; i++) begin
            send_load(TBL_FORE_BASE, IDX_W'(i), plausible_base());
            send_load(TBL_AFT_BASE, IDX_W'(i), plausible_base());
        end
        for (int i = 0; i < NUM_OFS; i++) begin
            send_load(TBL_FORE_OFS, IDX_W'(i), plausible_offset());
            send_load(TBL_AFT_OFS, IDX_W'(i), plausible_offset());
        end

        // Directed: value extremes, clamping both ways, band edges,
        // ignored offset slot, base load dropping the sign bit
        send_load(TBL_FORE_BASE, 3'd0, 35'h7_FFFF_FFFF);
        send_load(TBL_FORE_OFS, 3'd0, {1'b1, 34'b0});
        send_load(TBL_AFT_BASE, 3'd0, '0);
        send_load(TBL_AFT_OFS, 3'd0, 35'h3_FFFF_FFFF);
        send_advance();
        send_load(TBL_FORE_BASE, 3'd0, 35'd10799999999);
        send_load(TBL_FORE_OFS, 3'd0, '0);
        send_load(TBL_AFT_BASE, 3'd0, 35'd8000000000);
        send_load(TBL_AFT_OFS, 3'd0, '0);
        send_advance();
        send_load(TBL_FORE_OFS, 3'd7, 35'h3_FFFF_FFFF);
        send_load(TBL_AFT_OFS, 3'd7, {1'b1, 34'b0});
        send_advance();
        send_load(TBL_FORE_BASE, 3'd0, 35'd9000000000);
        send_load(TBL_AFT_BASE, 3'd0, 35'd8999999999);
        send_advance();
        send_load(TBL_FORE_BASE, 3'd0, 35'd10800000000);
        send_load(TBL_AFT_BASE, 3'd0, 35'd7999999999);
        send_advance();
        send_load(TBL_FORE_OFS, 3'd0, -35'sd1);
        send_load(TBL_AFT_OFS, 3'd0, 35'sd1);
        send_advance();
        send_load(TBL_FORE_BASE, 3'd7, 35'd10000000000);
        send_advance();
        drain();

        // Random phases, each under its own register setting
        for (int ph = 0; ph < 6; ph++) begin
            if (ph < 2) begin
                send_idle_pct = 27;
                recv_idle_pct = 75;
            end else if (ph < 4) begin
                send_idle_pct = 75;
                recv_idle_pct = 27;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(REG_FREQ_COUNT, APB_DW'(phase_fc[ph]));
            write_reg(REG_ATTEN_STEP, APB_DW'(phase_step[ph]));
            write_reg(REG_ATTEN_LIMIT, APB_DW'(phase_limit[ph]));
            for (int n = 0; n < PHASE_CMDS; n++) send_random_cmd();
            drain();
        end

        $display("%0d table loads and %0d sweep advances over 7 register settings;",
                 n_loads, n_advances);
        $display("%0d DDS programs checked, %0d of them closing an attenuation run.",
                 n_beats, n_last);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/tpsdds_pkg.sv
hw/rtl/tpsdds_intf.sv
hw/rtl/tpsdds_div.sv
hw/rtl/tpsdds_dpath.sv
hw/rtl/tpsdds_ctrl.sv
hw/rtl/test_pulse_sweep_dds_programmer_top.sv
test/testbench.sv
